// ----- rtl/rtmr_pkg.sv -----
package rtmr_pkg;

	localparam int unsigned COUNTER_WIDTH_DEF = 16;

	localparam int unsigned RUN_BIT      = 31;
	localparam int unsigned IRQ_EN_BIT   = 27;
	localparam int unsigned IRQ_FLAG_BIT = 26;
	localparam logic [31:0] IRQ_FLAG     = 32'h0400_0000;
	localparam logic [1:0]  MODE_TIMER   = 2'h0;

	localparam logic [5:0] OFF_CTRL    = 6'h00;
	localparam logic [5:0] OFF_CTRL2   = 6'h01;
	localparam logic [5:0] OFF_PRELOAD = 6'h02;
	localparam logic [5:0] OFF_CCR     = 6'h03;
	localparam logic [5:0] OFF_UPCOUNT = 6'h04;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_CMD   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  word_offset;
		logic [31:0] data;
		logic [31:0] lane_mask;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
	} result_t;

endpackage

// ----- rtl/rtmr_core.sv -----
module rtmr_core #(
	parameter int unsigned COUNTER_WIDTH = rtmr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  rtmr_pkg::item_t   item,
	output rtmr_pkg::result_t result
);

	logic                     run_q, run_d;
	logic [31:0]              ctrl_q, ctrl_d, ctrl_w;
	logic [31:0]              mode_q, mode_d;
	logic [31:0]              pre_q, pre_d;
	logic [31:0]              ccr_q, ccr_d;
	logic [31:0]              upc_q, upc_d;
	logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d;
	logic                     irq_q, irq_d;
	logic [31:0]              rd;

	function automatic logic [31:0] merge(input logic [31:0] old, input logic [31:0] wd,
			input logic [31:0] msk);
		return (old & ~msk) | (wd & msk);
	endfunction

	always_comb begin
		run_d  = run_q;
		ctrl_d = ctrl_q;
		mode_d = mode_q;
		pre_d  = pre_q;
		ccr_d  = ccr_q;
		upc_d  = upc_q;
		cnt_d  = cnt_q;
		irq_d  = irq_q;
		rd     = '0;
		ctrl_w = merge(ctrl_q, item.data, item.lane_mask);
		unique case (item.kind)
			rtmr_pkg::KIND_TICK: begin
				if (run_q && ctrl_q[rtmr_pkg::RUN_BIT] && mode_q[31:30] == rtmr_pkg::MODE_TIMER) begin
					if (&cnt_q) begin
						cnt_d = pre_q[COUNTER_WIDTH-1:0];
						if (ctrl_q[rtmr_pkg::IRQ_EN_BIT]) begin
							ctrl_d = ctrl_q | rtmr_pkg::IRQ_FLAG;
							irq_d  = 1'b1;
						end
					end else begin
						cnt_d = cnt_q + COUNTER_WIDTH'(1);
					end
				end
			end
			rtmr_pkg::KIND_READ: begin
				unique case (item.word_offset)
					rtmr_pkg::OFF_CTRL:    rd = ctrl_q;
					rtmr_pkg::OFF_CTRL2:   rd = mode_q;
					rtmr_pkg::OFF_PRELOAD: rd = pre_q;
					rtmr_pkg::OFF_CCR:     rd = ccr_q;
					rtmr_pkg::OFF_UPCOUNT: rd = upc_q;
					default:               rd = '0;
				endcase
			end
			rtmr_pkg::KIND_WRITE: begin
				unique case (item.word_offset)
					rtmr_pkg::OFF_CTRL: begin
						// flag is write-one-to-clear when the top byte is addressed
						if (|item.lane_mask[31:24]) begin
							ctrl_d = ctrl_w & ~(item.data & rtmr_pkg::IRQ_FLAG);
							if (!ctrl_d[rtmr_pkg::IRQ_FLAG_BIT]) begin
								irq_d = 1'b0;
							end
						end else begin
							ctrl_d = ctrl_w;
						end
					end
					rtmr_pkg::OFF_CTRL2:   mode_d = merge(mode_q, item.data, item.lane_mask);
					rtmr_pkg::OFF_PRELOAD: pre_d  = merge(pre_q, item.data, item.lane_mask);
					rtmr_pkg::OFF_CCR:     ccr_d  = merge(ccr_q, item.data, item.lane_mask);
					rtmr_pkg::OFF_UPCOUNT: upc_d  = merge(upc_q, item.data, item.lane_mask);
					default: begin
					end
				endcase
			end
			rtmr_pkg::KIND_CMD: begin
				run_d = item.data[0];
				if (item.data[1]) begin
					cnt_d = pre_q[COUNTER_WIDTH-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ctrl_q <= '0;
			mode_q <= '0;
			pre_q  <= '0;
			ccr_q  <= '0;
			upc_q  <= '0;
			cnt_q  <= '0;
			irq_q  <= 1'b0;
		end else if (step) begin
			run_q  <= run_d;
			ctrl_q <= ctrl_d;
			mode_q <= mode_d;
			pre_q  <= pre_d;
			ccr_q  <= ccr_d;
			upc_q  <= upc_d;
			cnt_q  <= cnt_d;
			irq_q  <= irq_d;
		end
	end

	assign result.read_data = rd;
	assign result.irq       = irq_d;

endmodule

// ----- rtl/reload_timer_with_irq_registers.sv -----
// channel   direction  handshake             fields
// req       in         req_valid/req_stall   kind, word_offset, data, lane_mask
// rsp       out        rsp_valid/rsp_stall   read_data, irq
//
// One request per cycle sustained while rsp_stall does not hold a waiting result.
// Request register, then one pass through the register bank into the result register.
// Register state changes when a request leaves the request register.
// arst_n clears all timer registers, the core's irq state and both valid flags (not the result register).
// rsp_stall holds the result register; req_stall rises only while both stages are full.
module reload_timer_with_irq_registers #(
	parameter int unsigned COUNTER_WIDTH = rtmr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [5:0]  word_offset,
	input  logic [31:0] data,
	input  logic [31:0] lane_mask,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] read_data,
	output logic        irq
);

	logic              valid_s1;
	rtmr_pkg::item_t   item_s1;
	logic              rsp_valid_q;
	rtmr_pkg::result_t result_q;
	rtmr_pkg::result_t result;
	logic              adv;
	logic              step;
	logic              take;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign step      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind        <= rtmr_pkg::kind_t'(kind);
			item_s1.word_offset <= word_offset;
			item_s1.data        <= data;
			item_s1.lane_mask   <= lane_mask;
		end
	end

	rtmr_core #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = result_q.read_data;
	assign irq       = result_q.irq;

endmodule

// ----- rtl/rtmr_checker.sv -----
module rtmr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] read_data,
	input logic        irq
);

	logic [1:0] pending_q;
	logic       req_take;
	logic       rsp_take;

	assign req_take = req_valid && !req_stall;
	assign rsp_take = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_take) - 2'(rsp_take);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(irq))
		else $error("stalled response changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a stalled response");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> !rsp_valid)
		else $error("response without a request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests in flight");

endmodule

bind reload_timer_with_irq_registers rtmr_checker u_rtmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.read_data (read_data),
	.irq       (irq)
);

// ----- verif/tb_reload_timer_with_irq_registers.sv -----
`timescale 1ns / 1ps

module tb_reload_timer_with_irq_registers;

	localparam int unsigned CW          = rtmr_pkg::COUNTER_WIDTH_DEF;
	localparam int unsigned STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  kind;
	logic [5:0]  word_offset;
	logic [31:0] data;
	logic [31:0] lane_mask;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [31:0] read_data;
	logic        irq;

	// expected timer state
	logic          tm_run;
	logic [31:0]   tm_ctrl;
	logic [31:0]   tm_mode;
	logic [31:0]   tm_preload;
	logic [31:0]   tm_ccr;
	logic [31:0]   tm_upcount;
	logic [CW-1:0] tm_count;
	logic          tm_irq;

	rtmr_pkg::result_t pending_results[$];
	int                mismatches;
	int                idle_cycles;
	bit                idling;

	reload_timer_with_irq_registers i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.word_offset (word_offset),
		.data        (data),
		.lane_mask   (lane_mask),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.read_data   (read_data),
		.irq         (irq)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] merged(logic [31:0] old, logic [31:0] d, logic [31:0] m);
		return (old & ~m) | (d & m);
	endfunction

	task automatic advance_timer(rtmr_pkg::kind_t k, logic [5:0] off, logic [31:0] d,
			logic [31:0] m);
		rtmr_pkg::result_t r;
		r.read_data = '0;
		case (k)
			rtmr_pkg::KIND_TICK: begin
				if (tm_run && tm_ctrl[rtmr_pkg::RUN_BIT]
						&& tm_mode[31:30] == rtmr_pkg::MODE_TIMER) begin
					if (tm_count == '1) begin
						tm_count = tm_preload[CW-1:0];
						if (tm_ctrl[rtmr_pkg::IRQ_EN_BIT]) begin
							tm_ctrl = tm_ctrl | rtmr_pkg::IRQ_FLAG;
							tm_irq  = 1'b1;
						end
					end else begin
						tm_count = tm_count + 1'b1;
					end
				end
			end
			rtmr_pkg::KIND_READ: begin
				case (off)
					rtmr_pkg::OFF_CTRL:    r.read_data = tm_ctrl;
					rtmr_pkg::OFF_CTRL2:   r.read_data = tm_mode;
					rtmr_pkg::OFF_PRELOAD: r.read_data = tm_preload;
					rtmr_pkg::OFF_CCR:     r.read_data = tm_ccr;
					rtmr_pkg::OFF_UPCOUNT: r.read_data = tm_upcount;
					default:               r.read_data = '0;
				endcase
			end
			rtmr_pkg::KIND_WRITE: begin
				case (off)
					rtmr_pkg::OFF_CTRL: begin
						tm_ctrl = merged(tm_ctrl, d, m);
						// flag is write-one-to-clear when the top byte is touched
						if (|m[31:24]) begin
							tm_ctrl = tm_ctrl & ~(d & rtmr_pkg::IRQ_FLAG);
							if (!tm_ctrl[rtmr_pkg::IRQ_FLAG_BIT])
								tm_irq = 1'b0;
						end
					end
					rtmr_pkg::OFF_CTRL2:   tm_mode    = merged(tm_mode, d, m);
					rtmr_pkg::OFF_PRELOAD: tm_preload = merged(tm_preload, d, m);
					rtmr_pkg::OFF_CCR:     tm_ccr     = merged(tm_ccr, d, m);
					rtmr_pkg::OFF_UPCOUNT: tm_upcount = merged(tm_upcount, d, m);
					default: ;
				endcase
			end
			default: begin
				tm_run = d[0];
				if (d[1])
					tm_count = tm_preload[CW-1:0];
			end
		endcase
		r.irq = tm_irq;
		pending_results.push_back(r);
	endtask

	task automatic report_mismatch(string what);
		$display("%0t: %s", $time, what);
		mismatches++;
	endtask

	// entered and left just after a falling edge
	task automatic send_request(rtmr_pkg::kind_t k, logic [5:0] off, logic [31:0] d,
			logic [31:0] m);
		if (idling && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req_valid   <= 1'b1;
		kind        <= k;
		word_offset <= off;
		data        <= d;
		lane_mask   <= m;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		advance_timer(k, off, d, m);
		@(negedge clk);
	endtask

	task automatic test_reset_values();
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_CTRL, '0, '0);
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_UPCOUNT, '0, '0);
		send_request(rtmr_pkg::KIND_WRITE, 6'h3f, '1, '1);
		send_request(rtmr_pkg::KIND_READ, 6'h3f, '0, '0);
		send_request(rtmr_pkg::KIND_READ, 6'h05, '1, '1);
	endtask

	task automatic test_register_masks();
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_PRELOAD, 32'hffff_fffe, '1);
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_CCR, '1, 32'h0f0f_0f0f);
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_UPCOUNT, 32'ha5a5_a5a5, '1);
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_UPCOUNT, '0, '0);
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_PRELOAD, '0, '0);
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_CCR, '0, '0);
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_UPCOUNT, '0, '0);
	endtask

	task automatic test_reload_and_irq();
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_CTRL, 32'h8800_0000, '1);
		send_request(rtmr_pkg::KIND_CMD, 6'h3f, 32'h0000_0003, '1);
		// two wraps, the second with the flag already set
		repeat (4)
			send_request(rtmr_pkg::KIND_TICK, '0, '0, '0);
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_CTRL, '0, '0);
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_CTRL, 32'h8c00_0000, 32'hff00_0000);
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_CTRL, '0, '0);
	endtask

	task automatic test_other_modes();
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_CTRL2, 32'hc000_0000, '1);
		send_request(rtmr_pkg::KIND_TICK, '0, '0, '0);
		send_request(rtmr_pkg::KIND_READ, rtmr_pkg::OFF_CTRL2, '0, '0);
		send_request(rtmr_pkg::KIND_WRITE, rtmr_pkg::OFF_CTRL2, '0, 32'hc000_0000);
		send_request(rtmr_pkg::KIND_CMD, '0, '0, '0);
		send_request(rtmr_pkg::KIND_TICK, '0, '0, '0);
	endtask

	task automatic test_random_traffic(int count);
		rtmr_pkg::kind_t k;
		logic [5:0]      off;
		logic [31:0]     d;
		logic [31:0]     m;
		int              sel;
		repeat (count) begin
			sel = $urandom_range(0, 9);
			if (sel < 5)
				k = rtmr_pkg::KIND_TICK;
			else if (sel < 7)
				k = rtmr_pkg::KIND_READ;
			else if (sel < 9)
				k = rtmr_pkg::KIND_WRITE;
			else
				k = rtmr_pkg::KIND_CMD;
			off = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 4));
			d = $urandom;
			case ($urandom_range(0, 3))
				0:       m = '1;
				1:       m = '0;
				2:       m = 32'hff << (8 * $urandom_range(0, 3));
				default: m = $urandom;
			endcase
			if (k == rtmr_pkg::KIND_WRITE && $urandom_range(0, 3) != 0) begin
				case (off)
					rtmr_pkg::OFF_CTRL:    d = d | 32'h8800_0000;
					rtmr_pkg::OFF_CTRL2:   d[31:30] = rtmr_pkg::MODE_TIMER;
					rtmr_pkg::OFF_PRELOAD: d[15:0] = 16'($urandom_range(16'hfff0, 16'hffff));
					default: ;
				endcase
			end
			if (k == rtmr_pkg::KIND_CMD && $urandom_range(0, 3) != 0)
				d[0] = 1'b1;
			send_request(k, off, d, m);
		end
	endtask

	always begin
		@(negedge clk);
		if (idling && $urandom_range(0, 7) == 0) begin
			rsp_stall <= 1'b1;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		rsp_stall <= 1'b0;
	end

	always @(posedge clk) begin
		rtmr_pkg::result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data)
					report_mismatch($sformatf("read_data %h, want %h", read_data,
						want.read_data));
				if (irq !== want.irq)
					report_mismatch($sformatf("irq %b, want %b", irq, want.irq));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("reload_timer_with_irq_registers: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		kind        = rtmr_pkg::KIND_TICK;
		word_offset = '0;
		data        = '0;
		lane_mask   = '0;
		rsp_stall   = 1'b0;
		idling      = 1'b0;
		mismatches  = 0;
		idle_cycles = 0;
		tm_run      = 1'b0;
		tm_ctrl     = '0;
		tm_mode     = '0;
		tm_preload  = '0;
		tm_ccr      = '0;
		tm_upcount  = '0;
		tm_count    = '0;
		tm_irq      = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idling = 1'b1;
		test_reset_values();
		test_register_masks();
		test_reload_and_irq();
		test_other_modes();
		test_random_traffic(1100);
		idling = 1'b0;
		test_random_traffic(250);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("reload_timer_with_irq_registers: match");
		else
			$display("reload_timer_with_irq_registers: mismatch");
		$finish;
	end

endmodule

// ----- reload_timer_with_irq_registers.f -----
rtl/rtmr_pkg.sv
rtl/rtmr_core.sv
rtl/reload_timer_with_irq_registers.sv
rtl/rtmr_checker.sv
verif/tb_reload_timer_with_irq_registers.sv
